>>> design/usb_midi_packet_to_port_fifos_core_assert.svh
// assertion macros for the usb midi packet decoder
`ifndef USB_MIDI_PACKET_TO_PORT_FIFOS_CORE_ASSERT_SVH
`define USB_MIDI_PACKET_TO_PORT_FIFOS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define UMIDI_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("umidi assertion failed");

// property checked only where its condition holds
`define UMIDI_ASSERT_IF(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("umidi assertion failed");

`else

`define UMIDI_ASSERT(label, prop)
`define UMIDI_ASSERT_IF(label, cond, prop)

`endif

`endif

>>> design/umidi_pkg.sv
`default_nettype none

package umidi_pkg;

  // default sizes
  localparam int PORT_COUNT_DEF = 8;
  localparam int RING_DEPTH_DEF = 64;

  // only this many ports have a ready bit on a drain item
  localparam int MASK_PORTS = 8;

  // input command codes
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // packet status codes
  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_DROPPED  = 2'd1,
    STATUS_REFUSED  = 2'd2
  } status_t;

  // code index to number of midi payload bytes
  function automatic logic [1:0] code_len(input logic [3:0] cin);
    logic [1:0] n;
    case (cin)
      4'h0: n = 2'd0;
      4'h1: n = 2'd0;
      4'h2: n = 2'd2;
      4'h3: n = 2'd3;
      4'h4: n = 2'd3;
      4'h5: n = 2'd1;
      4'h6: n = 2'd2;
      4'h7: n = 2'd3;
      4'h8: n = 2'd3;
      4'h9: n = 2'd3;
      4'hA: n = 2'd3;
      4'hB: n = 2'd3;
      4'hC: n = 2'd2;
      4'hD: n = 2'd2;
      4'hE: n = 2'd3;
      4'hF: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/umidi_in_if.sv
`default_nettype none

// input channel: event packet or drain item
interface umidi_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] header_byte;
  logic [7:0] payload_first;
  logic [7:0] payload_second;
  logic [7:0] payload_third;
  logic [7:0] ready_mask;

  modport source (
    output valid, command, header_byte, payload_first, payload_second,
           payload_third, ready_mask,
    input  ready
  );

  modport sink (
    input  valid, command, header_byte, payload_first, payload_second,
           payload_third, ready_mask,
    output ready
  );
endinterface

`default_nettype wire

>>> design/umidi_out_if.sv
`default_nettype none

// result channel: packet status or byte for a port
interface umidi_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] status;
  logic [2:0] port;
  logic [7:0] out_byte;
  logic       last;

  modport source (
    output valid, kind, status, port, out_byte, last,
    input  ready
  );

  modport sink (
    input  valid, kind, status, port, out_byte, last,
    output ready
  );
endinterface

`default_nettype wire

>>> design/usb_midi_packet_to_port_fifos_core.sv
// USB-MIDI event packet decoder with one transmit ring per port. A packet item
// (command 0) is checked in the cycle it is accepted; if it passes, its 1 to 3
// payload bytes are written into the cable's ring one per cycle through the
// single write port of the ring memory. Every packet then presents one status
// result. A drain item (command 1) picks every ready, nonempty port among
// ports 0..7 in ascending order; each pick reads one byte of the ring memory
// into registered read data (S_DRAIN_RD) and then loads it into the result
// register (S_DRAIN_OUT), and a drain with nothing to send gives no result and
// frees the input at once. Results wait in an output register: the next item
// is taken while a result is still pending, and the block only stalls when it
// must present a new result before the old one is taken. Ring contents need no
// clearing; the per-port read and write indexes are cleared by reset.
`default_nettype none

`include "usb_midi_packet_to_port_fifos_core_assert.svh"

module usb_midi_packet_to_port_fifos_core
  import umidi_pkg::*;
#(
  parameter int PORT_COUNT = PORT_COUNT_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  umidi_in_if.sink     in_chan,
  umidi_out_if.source  out_chan
);

  // derived sizes
  localparam int PW  = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int IW  = $clog2(RING_DEPTH);
  localparam int UW  = IW + 1;
  localparam int MD  = PORT_COUNT * RING_DEPTH;
  localparam int MAW = $clog2(MD);
  localparam int ND  = (PORT_COUNT < MASK_PORTS) ? PORT_COUNT : MASK_PORTS;
  localparam int DSW = (ND > 1) ? $clog2(ND) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_STATUS,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } state_t;

  state_t          state_r;
  logic [IW-1:0]   wr_idx_r [PORT_COUNT];
  logic [IW-1:0]   rd_idx_r [PORT_COUNT];
  logic [3:0]      cable_r;
  logic [1:0]      len_r;
  logic [1:0]      wcnt_r;
  logic [7:0]      pay0_r;
  logic [7:0]      pay1_r;
  logic [7:0]      pay2_r;
  status_t         status_r;
  logic [ND-1:0]   drain_mask_r;
  logic [DSW-1:0]  drain_sel_r;
  logic [7:0]      ram_q_r;

  logic            out_valid_r;
  logic            out_kind_r;
  status_t         out_status_r;
  logic [2:0]      out_port_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;

  // ring memory, one region of RING_DEPTH bytes per port
  logic [7:0]      ring_mem [MD];

  logic            in_fire;
  logic            out_free;
  logic            out_load;
  logic [3:0]      in_cable;
  logic [PW-1:0]   in_idx;
  logic [1:0]      in_len;
  logic [IW-1:0]   in_w;
  logic [IW-1:0]   in_r;
  logic [UW-1:0]   in_used;
  logic            in_bad;
  logic            in_full;
  logic [ND-1:0]   in_elig;

  logic [PW-1:0]   cable_idx;
  logic [IW-1:0]   wr_slot;
  logic [IW-1:0]   wr_slot_nxt;
  logic [MAW-1:0]  wr_addr;
  logic [7:0]      wr_data;

  logic [DSW-1:0]  sel_c;
  logic [PW-1:0]   sel_idx;
  logic [MAW-1:0]  rd_addr;
  logic [PW-1:0]   dsel_idx;
  logic [IW-1:0]   rd_slot_nxt;
  logic [ND-1:0]   drain_rem;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign out_load = out_free && ((state_r == S_STATUS) || (state_r == S_DRAIN_OUT));
  assign in_chan.ready = (state_r == S_IDLE);

  // packet checks on the incoming item
  assign in_cable = in_chan.header_byte[7:4];
  assign in_idx   = in_cable[PW-1:0];
  assign in_len   = code_len(in_chan.header_byte[3:0]);
  assign in_w     = wr_idx_r[in_idx];
  assign in_r     = rd_idx_r[in_idx];
  assign in_used  = (in_w >= in_r) ? (UW'(in_w) - UW'(in_r))
                                   : (UW'(in_w) + UW'(RING_DEPTH) - UW'(in_r));
  assign in_bad   = ({1'b0, in_cable} >= 5'(PORT_COUNT)) || (in_len == 2'd0);
  assign in_full  = (in_used + UW'(in_len)) > UW'(RING_DEPTH - 1);

  // ports that can send on a drain item
  always_comb begin
    for (int p = 0; p < ND; p++) begin
      in_elig[p] = in_chan.ready_mask[p] && (wr_idx_r[p] != rd_idx_r[p]);
    end
  end

  // write side address and data
  assign cable_idx   = cable_r[PW-1:0];
  assign wr_slot     = wr_idx_r[cable_idx];
  assign wr_slot_nxt = (wr_slot == IW'(RING_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
  assign wr_addr     = MAW'(cable_idx) * MAW'(RING_DEPTH) + MAW'(wr_slot);

  always_comb begin
    case (wcnt_r)
      2'd0:    wr_data = pay0_r;
      2'd1:    wr_data = pay1_r;
      default: wr_data = pay2_r;
    endcase
  end

  // lowest pending drain port
  always_comb begin
    sel_c = '0;
    for (int p = ND - 1; p >= 0; p--) begin
      if (drain_mask_r[p]) begin
        sel_c = DSW'(p);
      end
    end
  end

  assign sel_idx     = PW'(sel_c);
  assign rd_addr     = MAW'(sel_idx) * MAW'(RING_DEPTH) + MAW'(rd_idx_r[sel_idx]);
  assign dsel_idx    = PW'(drain_sel_r);
  assign rd_slot_nxt = (rd_idx_r[dsel_idx] == IW'(RING_DEPTH - 1)) ? '0
                                                                   : rd_idx_r[dsel_idx] + 1'b1;
  assign drain_rem   = drain_mask_r & ~(ND'(1) << drain_sel_r);

  // ring memory ports
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (state_r == S_DRAIN_RD) begin
      ram_q_r <= ring_mem[rd_addr];
    end
  end

  // sequencer, indexes and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      drain_mask_r <= '0;
      for (int p = 0; p < PORT_COUNT; p++) begin
        wr_idx_r[p] <= '0;
        rd_idx_r[p] <= '0;
      end
    end else begin
      // result register: a new result wins over a taken one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_chan.command == CMD_PACKET) begin
              cable_r <= in_cable;
              len_r   <= in_len;
              wcnt_r  <= 2'd0;
              pay0_r  <= in_chan.payload_first;
              pay1_r  <= in_chan.payload_second;
              pay2_r  <= in_chan.payload_third;
              if (in_bad) begin
                status_r <= STATUS_DROPPED;
                state_r  <= S_STATUS;
              end else if (in_full) begin
                status_r <= STATUS_REFUSED;
                state_r  <= S_STATUS;
              end else begin
                status_r <= STATUS_ACCEPTED;
                state_r  <= S_WRITE;
              end
            end else if (in_elig != '0) begin
              drain_mask_r <= in_elig;
              state_r      <= S_DRAIN_RD;
            end
          end
        end
        S_WRITE: begin
          wr_idx_r[cable_idx] <= wr_slot_nxt;
          wcnt_r              <= wcnt_r + 2'd1;
          if (wcnt_r == len_r - 2'd1) begin
            state_r <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_kind_r   <= KIND_STATUS;
            out_status_r <= status_r;
            out_port_r   <= cable_r[2:0];
            out_byte_r   <= 8'd0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_DRAIN_RD: begin
          drain_sel_r <= sel_c;
          state_r     <= S_DRAIN_OUT;
        end
        S_DRAIN_OUT: begin
          if (out_free) begin
            out_kind_r         <= KIND_BYTE;
            out_status_r       <= STATUS_ACCEPTED;
            out_port_r         <= 3'(drain_sel_r);
            out_byte_r         <= ram_q_r;
            out_last_r         <= (drain_rem == '0);
            rd_idx_r[dsel_idx] <= rd_slot_nxt;
            drain_mask_r       <= drain_rem;
            state_r            <= (drain_rem == '0) ? S_IDLE : S_DRAIN_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign out_chan.valid    = out_valid_r;
  assign out_chan.kind     = out_kind_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.port     = out_port_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;

  // a write never fills the slot kept free in the ring
  `UMIDI_ASSERT_IF(a_no_overflow, state_r == S_WRITE, wr_slot_nxt != rd_idx_r[cable_idx])
  // a packet writes no more bytes than its code index allows
  `UMIDI_ASSERT_IF(a_write_count, state_r == S_WRITE, wcnt_r < len_r)
  // a drain only reads from a port that holds data
  `UMIDI_ASSERT_IF(a_drain_nonempty, state_r == S_DRAIN_OUT,
                   wr_idx_r[dsel_idx] != rd_idx_r[dsel_idx])
  // no drain work left over once the input side is open again
  `UMIDI_ASSERT_IF(a_idle_no_drain, state_r == S_IDLE, drain_mask_r == '0)
  // a packet status always closes its item
  `UMIDI_ASSERT_IF(a_status_last, out_valid_r && out_kind_r == KIND_STATUS, out_last_r)

endmodule

`default_nettype wire
